### rtl/core/ip_transport_header_parser_unit_assert.svh
// Assertion macros used by the header parser checker
`ifndef IP_TRANSPORT_HEADER_PARSER_UNIT_ASSERT_SVH
`define IP_TRANSPORT_HEADER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPHP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPHP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/iphp_pkg.sv
// Shared types and constants for the IP / transport header parser
package iphp_pkg;

   localparam int IP_BYTES = 40;
   localparam int TP_BYTES = 20;
   localparam int V4_MIN   = 20;
   localparam int V6_LEN   = 40;
   localparam int TCP_MIN  = 20;
   localparam int UDP_LEN  = 8;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [3:0] VER_V4    = 4'd4;
   localparam logic [3:0] VER_V6    = 4'd6;

   typedef enum logic [4:0] {
      KIND_STATUS      = 5'd0,
      KIND_VERSION     = 5'd1,
      KIND_IP_HDR_LEN  = 5'd2,
      KIND_TOTAL_LEN   = 5'd3,
      KIND_ID          = 5'd4,
      KIND_DF          = 5'd5,
      KIND_MF          = 5'd6,
      KIND_FRAG_OFF    = 5'd7,
      KIND_IS_FRAG     = 5'd8,
      KIND_TTL         = 5'd9,
      KIND_PROTO       = 5'd10,
      KIND_SRC_HI      = 5'd11,
      KIND_SRC_LO      = 5'd12,
      KIND_DST_HI      = 5'd13,
      KIND_DST_LO      = 5'd14,
      KIND_SRC_PORT    = 5'd15,
      KIND_DST_PORT    = 5'd16,
      KIND_TCP_SEQ     = 5'd17,
      KIND_TCP_ACK     = 5'd18,
      KIND_TCP_HDR_LEN = 5'd19,
      KIND_TCP_FLAGS   = 5'd20,
      KIND_TCP_WINDOW  = 5'd21,
      KIND_TCP_URGENT  = 5'd22,
      KIND_TCP_OPT_LEN = 5'd23,
      KIND_UDP_LEN     = 5'd24,
      KIND_UDP_CSUM    = 5'd25,
      KIND_PAYLOAD_OFF = 5'd26,
      KIND_PAYLOAD_LEN = 5'd27
   } kind_type;

   // captured header of one packet; byte i of each header sits at index i
   typedef struct packed {
      logic [IP_BYTES-1:0][7:0] ip_hdr;
      logic [TP_BYTES-1:0][7:0] tp_hdr;
      logic [15:0]              pkt_len;
   } snap_type;

endpackage

### rtl/core/iphp_queue.sv
// Small register FIFO between the capture and emission sides
module iphp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][WIDTH-1:0] mem_ff;
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/iphp_front.sv
// Byte capture: packet length count and header byte capture per packet
module iphp_front
   import iphp_pkg::*;
#(
   parameter int HEADER_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_packet_byte,
   input  logic       req_end_of_packet,
   input  logic       q_full,
   output logic       q_push,
   output snap_type   q_data
);

   logic [15:0]              count_ff, count_in;
   logic [5:0]               tbase_ff, tbase_in;
   logic [IP_BYTES-1:0][7:0] ip_ff, ip_in;
   logic [TP_BYTES-1:0][7:0] tp_ff, tp_in;
   logic                     accept;
   logic [15:0]              len_next;
   logic [15:0]              tp_off;
   logic [7:0]               wr_byte;

   assign req_stall = q_full;

   always_comb begin
      accept   = req_valid && !q_full;
      len_next = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
      // bytes past the store read as zero
      wr_byte  = (count_ff < 16'(HEADER_BYTES)) ? req_packet_byte : 8'd0;
      tp_off   = count_ff - {10'd0, tbase_ff};
      ip_in    = ip_ff;
      tp_in    = tp_ff;
      count_in = count_ff;
      tbase_in = tbase_ff;
      if (accept) begin
         if (count_ff < 16'(IP_BYTES)) begin
            ip_in[count_ff[5:0]] = wr_byte;
         end
         if (count_ff >= {10'd0, tbase_ff} && tp_off < 16'(TP_BYTES)) begin
            tp_in[tp_off[4:0]] = wr_byte;
         end
         if (count_ff == '0) begin
            tbase_in = (req_packet_byte[7:4] == VER_V6) ? 6'(V6_LEN)
                                                         : {req_packet_byte[3:0], 2'b00};
         end
         count_in = req_end_of_packet ? 16'd0 : len_next;
      end
      q_push         = accept && req_end_of_packet;
      q_data.ip_hdr  = ip_in;
      q_data.tp_hdr  = tp_in;
      q_data.pkt_len = len_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tbase_ff <= '0;
      end else begin
         count_ff <= count_in;
         tbase_ff <= tbase_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff <= ip_in;
      tp_ff <= tp_in;
   end

endmodule

### rtl/core/iphp_back.sv
// Header checks and record emission for one queued packet at a time
module iphp_back
   import iphp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  snap_type    q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_record_kind,
   output logic [63:0] rsp_record_value,
   output logic        rsp_last_record
);

   typedef enum logic {
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_TCP,
      CLS_UDP
   } cls_type;

   function automatic logic [63:0] ip_be(input logic [IP_BYTES-1:0][7:0] h,
                                         input int unsigned first,
                                         input int unsigned n);
      logic [63:0] acc;
      acc = '0;
      for (int unsigned k = 0; k < 8; k++) begin
         if (k < n) begin
            acc = {acc[55:0], h[6'(first + k)]};
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] tp_be(input logic [TP_BYTES-1:0][7:0] h,
                                         input int unsigned first,
                                         input int unsigned n);
      logic [63:0] acc;
      acc = '0;
      for (int unsigned k = 0; k < 8; k++) begin
         if (k < n) begin
            acc = {acc[55:0], h[5'(first + k)]};
         end
      end
      return acc;
   endfunction

   state_type   state_ff;
   kind_type    kind_ff, next_kind;
   logic        ok_ff;
   cls_type     cls_ff;
   logic [5:0]  iphl_ff, thl_ff;
   logic [6:0]  poff_ff;
   logic [15:0] plen_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   kind_type    rsp_kind_ff;
   logic [63:0] rsp_value_ff;

   logic [IP_BYTES-1:0][7:0] ip;
   logic [TP_BYTES-1:0][7:0] tp;
   logic [15:0] len;
   logic [3:0]  ver;
   logic        is_v6;
   logic [5:0]  ihl4, iphl_c, tcp_thl, thl_c;
   logic [7:0]  proto_c;
   logic [15:0] tlen_c, plen_c;
   logic [6:0]  poff_c;
   logic [16:0] total_v6;
   logic        ip_ok, tp_ok, ok_c, has_pay;
   cls_type     cls_c;
   logic        out_free, emit_last;
   logic [63:0] value_c;

   // header checks on the queue head
   always_comb begin
      ip       = q_data.ip_hdr;
      tp       = q_data.tp_hdr;
      len      = q_data.pkt_len;
      ver      = ip[0][7:4];
      is_v6    = (ver == VER_V6);
      ihl4     = {ip[0][3:0], 2'b00};
      iphl_c   = is_v6 ? 6'(V6_LEN) : ihl4;
      proto_c  = is_v6 ? ip[6] : ip[9];
      tlen_c   = len - {10'd0, iphl_c};
      tcp_thl  = {tp[12][7:4], 2'b00};
      total_v6 = 17'(V6_LEN) + {1'b0, ip[4], ip[5]};
      if (ver == VER_V4) begin
         ip_ok = (len >= 16'(V4_MIN)) && (ihl4 >= 6'(V4_MIN)) && ({10'd0, ihl4} <= len);
      end else if (is_v6) begin
         ip_ok = (len >= 16'(V6_LEN));
      end else begin
         ip_ok = 1'b0;
      end
      if (proto_c == PROTO_TCP) begin
         cls_c = CLS_TCP;
         thl_c = tcp_thl;
         tp_ok = (tlen_c >= 16'(TCP_MIN)) && (tcp_thl >= 6'(TCP_MIN))
                 && ({10'd0, tcp_thl} <= tlen_c);
      end else if (proto_c == PROTO_UDP) begin
         cls_c = CLS_UDP;
         thl_c = 6'(UDP_LEN);
         tp_ok = (tlen_c >= 16'(UDP_LEN));
      end else begin
         cls_c = CLS_OTHER;
         thl_c = 6'd0;
         tp_ok = 1'b1;
      end
      ok_c    = ip_ok && tp_ok;
      has_pay = (thl_c != 6'd0) && ({10'd0, thl_c} < tlen_c);
      poff_c  = has_pay ? {1'b0, iphl_c} + {1'b0, thl_c} : 7'd0;
      plen_c  = has_pay ? tlen_c - {10'd0, thl_c} : 16'd0;
   end

   always_comb begin
      unique case (kind_ff)
         KIND_DST_PORT: begin
            if (cls_ff == CLS_TCP) begin
               next_kind = KIND_TCP_SEQ;
            end else if (cls_ff == CLS_UDP) begin
               next_kind = KIND_UDP_LEN;
            end else begin
               next_kind = KIND_PAYLOAD_OFF;
            end
         end
         KIND_TCP_OPT_LEN: next_kind = KIND_PAYLOAD_OFF;
         KIND_UDP_CSUM:    next_kind = KIND_PAYLOAD_OFF;
         default:          next_kind = kind_type'(kind_ff + 5'd1);
      endcase
   end

   always_comb begin
      unique case (kind_ff)
         KIND_STATUS:      value_c = {63'd0, ~ok_ff};
         KIND_VERSION:     value_c = {60'd0, ver};
         KIND_IP_HDR_LEN:  value_c = {58'd0, iphl_ff};
         KIND_TOTAL_LEN:   value_c = is_v6 ? {47'd0, total_v6} : ip_be(ip, 2, 2);
         KIND_ID:          value_c = is_v6 ? 64'd0 : ip_be(ip, 4, 2);
         KIND_DF:          value_c = {63'd0, !is_v6 && ip[6][6]};
         KIND_MF:          value_c = {63'd0, !is_v6 && ip[6][5]};
         KIND_FRAG_OFF:    value_c = is_v6 ? 64'd0 : {48'd0, ip[6][4:0], ip[7], 3'b000};
         KIND_IS_FRAG:     value_c = {63'd0, !is_v6 && (ip[6][5] || (|{ip[6][4:0], ip[7]}))};
         KIND_TTL:         value_c = {56'd0, is_v6 ? ip[7] : ip[8]};
         KIND_PROTO:       value_c = {56'd0, proto_c};
         KIND_SRC_HI:      value_c = is_v6 ? ip_be(ip, 8, 8) : 64'd0;
         KIND_SRC_LO:      value_c = is_v6 ? ip_be(ip, 16, 8) : ip_be(ip, 12, 4);
         KIND_DST_HI:      value_c = is_v6 ? ip_be(ip, 24, 8) : 64'd0;
         KIND_DST_LO:      value_c = is_v6 ? ip_be(ip, 32, 8) : ip_be(ip, 16, 4);
         KIND_SRC_PORT:    value_c = (cls_ff == CLS_OTHER) ? 64'd0 : tp_be(tp, 0, 2);
         KIND_DST_PORT:    value_c = (cls_ff == CLS_OTHER) ? 64'd0 : tp_be(tp, 2, 2);
         KIND_TCP_SEQ:     value_c = tp_be(tp, 4, 4);
         KIND_TCP_ACK:     value_c = tp_be(tp, 8, 4);
         KIND_TCP_HDR_LEN: value_c = {58'd0, thl_ff};
         KIND_TCP_FLAGS:   value_c = {58'd0, tp[13][5:0]};
         KIND_TCP_WINDOW:  value_c = tp_be(tp, 14, 2);
         KIND_TCP_URGENT:  value_c = tp_be(tp, 18, 2);
         KIND_TCP_OPT_LEN: value_c = {58'd0, thl_ff - 6'(TCP_MIN)};
         KIND_UDP_LEN:     value_c = tp_be(tp, 4, 2);
         KIND_UDP_CSUM:    value_c = tp_be(tp, 6, 2);
         KIND_PAYLOAD_OFF: value_c = {57'd0, poff_ff};
         KIND_PAYLOAD_LEN: value_c = {48'd0, plen_ff};
         default:          value_c = 64'd0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = !ok_ff || (kind_ff == KIND_PAYLOAD_LEN);
   assign q_pop     = (state_ff == ST_EMIT) && out_free && emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CHECK;
         kind_ff      <= KIND_STATUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && rsp_stall) || ((state_ff == ST_EMIT) && out_free);
         unique case (state_ff)
            ST_CHECK: begin
               if (q_valid) begin
                  ok_ff    <= ok_c;
                  cls_ff   <= cls_c;
                  iphl_ff  <= iphl_c;
                  thl_ff   <= thl_c;
                  poff_ff  <= poff_c;
                  plen_ff  <= plen_c;
                  kind_ff  <= KIND_STATUS;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_kind_ff  <= kind_ff;
                  rsp_value_ff <= value_c;
                  rsp_last_ff  <= emit_last;
                  if (emit_last) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     kind_ff <= next_kind;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_kind  = rsp_kind_ff;
   assign rsp_record_value = rsp_value_ff;
   assign rsp_last_record  = rsp_last_ff;

endmodule

### rtl/core/ip_transport_header_parser_unit.sv
// First record of a packet: final byte pushed into the queue, head checked in ST_CHECK,
// record registered in ST_EMIT. Throughput: one packet byte per cycle while the queue
// is not full; records one per cycle while rsp_stall is low, 1 to 26 per packet.
// A two-entry packet queue sits between capture and emission; capture stalls when full.
// Reset (synchronous): clears byte count, queue, emission state and output valid;
// captured header bytes are not cleared.
module ip_transport_header_parser_unit
   import iphp_pkg::*;
#(
   parameter int HEADER_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_record_kind,
   output logic [63:0] rsp_record_value,
   output logic        rsp_last_record
);

   localparam int SNAP_W = $bits(snap_type);

   snap_type          push_snap, head_snap;
   logic [SNAP_W-1:0] push_vec, head_vec;
   logic              q_push, q_full, q_pop, q_valid;

   iphp_front #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packet_byte   (req_packet_byte),
      .req_end_of_packet (req_end_of_packet),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (push_snap)
   );

   assign push_vec  = push_snap;
   assign head_snap = snap_type'(head_vec);

   iphp_queue #(
      .WIDTH(SNAP_W),
      .DEPTH(2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_vec),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_vec)
   );

   iphp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (head_snap),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_record_value (rsp_record_value),
      .rsp_last_record  (rsp_last_record)
   );

endmodule

### rtl/core/iphp_checker.sv
// Port-level checker for the header parser, bound to the top level
`include "ip_transport_header_parser_unit_assert.svh"

module iphp_checker
   import iphp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_record_kind,
   input logic [63:0] rsp_record_value,
   input logic        rsp_last_record
);

   `IPHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall && !reset, rsp_valid && $stable(rsp_record_kind) && $stable(rsp_record_value) && $stable(rsp_last_record), "stalled record changed")

   `IPHP_ASSERT_NOW(a_fail_last, clock, reset, rsp_valid && rsp_record_kind == KIND_STATUS && rsp_record_value == 64'd1, rsp_last_record, "invalid status not final")

   `IPHP_ASSERT_NOW(a_last_kind, clock, reset, rsp_valid && rsp_last_record, rsp_record_kind == KIND_PAYLOAD_LEN || rsp_record_kind == KIND_STATUS, "final record of wrong kind")

   `IPHP_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "record valid after reset")

endmodule

bind ip_transport_header_parser_unit iphp_checker u_iphp_checker (.*);
